### design/lrae_pkg.sv
`default_nettype none

package lrae_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_RUN   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
   localparam int CORDIC_LAT   = CORDIC_RUN + 1;
   localparam int SQRT_LAT     = 32;
   localparam int DIV_STEPS    = 31;
   localparam int UNIT_LAT     = 3 + SQRT_LAT + DIV_STEPS + 1;
   localparam int TOTAL_LAT    = UNIT_LAT + 2 * CORDIC_LAT + 5;

   localparam int Q_DLY = UNIT_LAT;
   localparam int Z_DLY = CORDIC_LAT - 1;
   localparam int A_DLY = CORDIC_LAT + 1;
   localparam int D_DLY = TOTAL_LAT - SQRT_LAT - 5;
   localparam int G_DLY = TOTAL_LAT - 3;

   localparam int REQ_W = 288;
   localparam int RSP_W = 64;

   localparam int CW  = 36;
   localparam int AW  = 26;
   localparam int AXW = AW + 1;

   localparam logic signed [AW-1:0] ATAN_TAB [32] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
      26'sd234379, 26'sd117304, 26'sd58666, 26'sd29335,
      26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
      26'sd917, 26'sd458, 26'sd229, 26'sd115,
      26'sd57, 26'sd29, 26'sd14, 26'sd7,
      26'sd4, 26'sd2, 26'sd1, 26'sd0,
      26'sd0, 26'sd0, 26'sd0, 26'sd0,
      26'sd0, 26'sd0, 26'sd0, 26'sd0
   };

   localparam logic signed [AW-1:0]  HALF_TURN = 26'sd11796480;
   localparam logic signed [AXW-1:0] FULL_TURN = 27'sd23592960;
   localparam logic signed [AXW-1:0] ROUND_HALF = 27'sd512;
   localparam logic signed [AXW-1:0] EL_HI = 27'sd5760;
   localparam logic signed [AXW-1:0] EL_LO = -27'sd5760;
   localparam logic [15:0] INV_GAIN = 16'd39797;
   localparam logic [14:0] AZ_LIMIT = 15'd23040;

   typedef logic signed [31:0] comp_type;

   function automatic logic [4:0] lead_shift(input logic [30:0] m);
      logic [4:0] s;
      s = '0;
      for (int b = 0; b < 31; b++) begin
         if (m[b]) begin
            s = 5'(30 - b);
         end
      end
      return s;
   endfunction

   function automatic logic signed [65:0] trunc_q30(input logic signed [65:0] s);
      logic signed [65:0] bias;
      bias = s[65] ? 66'sd1073741823 : 66'sd0;
      return (s + bias) >>> 30;
   endfunction

endpackage

`default_nettype wire

### design/lrae_sqrt.sv
`default_nettype none

module lrae_sqrt (
   input  logic        clock,
   input  logic        en,
   input  logic [63:0] rad,
   output logic [31:0] root
);
   import lrae_pkg::*;

   logic [31:0] res_ff [SQRT_LAT];
   logic [63:0] rem_ff [SQRT_LAT];
   logic [31:0] res_in [SQRT_LAT];
   logic [63:0] rem_in [SQRT_LAT];
   logic [31:0] src_res [SQRT_LAT];
   logic [63:0] src_rem [SQRT_LAT];
   logic [65:0] trial [SQRT_LAT];

   always_comb begin
      for (int k = 0; k < SQRT_LAT; k++) begin
         src_res[k] = (k == 0) ? 32'd0 : res_ff[(k == 0) ? 0 : k - 1];
         src_rem[k] = (k == 0) ? rad : rem_ff[(k == 0) ? 0 : k - 1];
         trial[k] = (66'(src_res[k]) << (SQRT_LAT - k))
                  + (66'd1 << (2 * (SQRT_LAT - 1 - k)));
         if (66'(src_rem[k]) >= trial[k]) begin
            rem_in[k] = src_rem[k] - trial[k][63:0];
            res_in[k] = src_res[k] | (32'd1 << (SQRT_LAT - 1 - k));
         end else begin
            rem_in[k] = src_rem[k];
            res_in[k] = src_res[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQRT_LAT; k++) begin
            res_ff[k] <= res_in[k];
            rem_ff[k] <= rem_in[k];
         end
      end
   end

   assign root = res_ff[SQRT_LAT-1];

endmodule

`default_nettype wire

### design/lrae_unit.sv
`default_nettype none

module lrae_unit (
   input  logic               clock,
   input  logic               en,
   input  lrae_pkg::comp_type vin  [3],
   output lrae_pkg::comp_type uout [3]
);
   import lrae_pkg::*;

   logic [31:0] mag_w [3];
   logic [31:0] top_w;
   logic [4:0]  sh_w;
   comp_type    w_in [3];
   comp_type    w_ff [3];
   logic [61:0] sq_in [3];
   logic [61:0] sq_ff [3];
   logic [63:0] ss_in;
   logic [63:0] ss_ff;
   comp_type    wd_ff [SQRT_LAT+2][3];
   logic [31:0] root_w;

   logic [31:0] dn_ff   [DIV_STEPS];
   logic [62:0] dr_ff   [DIV_STEPS][3];
   logic [30:0] dq_ff   [DIV_STEPS][3];
   logic        dneg_ff [DIV_STEPS][3];
   logic [31:0] dn_in   [DIV_STEPS];
   logic [62:0] dr_in   [DIV_STEPS][3];
   logic [30:0] dq_in   [DIV_STEPS][3];
   logic        dneg_in [DIV_STEPS][3];
   logic [31:0] src_n   [DIV_STEPS];
   logic [62:0] src_r   [DIV_STEPS][3];
   logic [30:0] src_q   [DIV_STEPS][3];
   logic        src_g   [DIV_STEPS][3];
   logic [62:0] trial   [DIV_STEPS];
   comp_type    wlast   [3];
   comp_type    wabs    [3];
   comp_type    u_in    [3];
   comp_type    u_ff    [3];

   // normalize so the largest component sits in [2^30, 2^31)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_w[i] = vin[i][31] ? 32'(-vin[i]) : 32'(vin[i]);
      end
      top_w = mag_w[0];
      if (mag_w[1] > top_w) begin
         top_w = mag_w[1];
      end
      if (mag_w[2] > top_w) begin
         top_w = mag_w[2];
      end
      sh_w = lead_shift(top_w[30:0]);
      for (int i = 0; i < 3; i++) begin
         w_in[i]  = vin[i] <<< sh_w;
         sq_in[i] = 62'(w_ff[i] * w_ff[i]);
      end
      ss_in = 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
   end

   lrae_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (ss_ff),
      .root  (root_w)
   );

   // restoring divide: |w| * 2^30 / n, one quotient bit per stage
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wlast[i] = wd_ff[SQRT_LAT+1][i];
         wabs[i]  = wlast[i][31] ? -wlast[i] : wlast[i];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
         src_n[j] = (j == 0) ? root_w : dn_ff[(j == 0) ? 0 : j - 1];
         trial[j] = 63'(src_n[j]) << (DIV_STEPS - 1 - j);
         dn_in[j] = src_n[j];
         for (int i = 0; i < 3; i++) begin
            if (j == 0) begin
               src_r[j][i] = 63'({wabs[i][30:0], 30'd0});
               src_q[j][i] = '0;
               src_g[j][i] = wlast[i][31];
            end else begin
               src_r[j][i] = dr_ff[(j == 0) ? 0 : j - 1][i];
               src_q[j][i] = dq_ff[(j == 0) ? 0 : j - 1][i];
               src_g[j][i] = dneg_ff[(j == 0) ? 0 : j - 1][i];
            end
            dneg_in[j][i] = src_g[j][i];
            if (src_r[j][i] >= trial[j]) begin
               dr_in[j][i] = src_r[j][i] - trial[j];
               dq_in[j][i] = src_q[j][i] | (31'd1 << (DIV_STEPS - 1 - j));
            end else begin
               dr_in[j][i] = src_r[j][i];
               dq_in[j][i] = src_q[j][i];
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (dneg_ff[DIV_STEPS-1][i]) begin
            u_in[i] = -$signed({1'b0, dq_ff[DIV_STEPS-1][i]});
         end else begin
            u_in[i] = $signed({1'b0, dq_ff[DIV_STEPS-1][i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            w_ff[i]     <= w_in[i];
            sq_ff[i]    <= sq_in[i];
            wd_ff[0][i] <= w_ff[i];
            for (int k = 1; k < SQRT_LAT + 2; k++) begin
               wd_ff[k][i] <= wd_ff[k-1][i];
            end
            u_ff[i] <= u_in[i];
         end
         ss_ff <= ss_in;
         for (int j = 0; j < DIV_STEPS; j++) begin
            dn_ff[j] <= dn_in[j];
            for (int i = 0; i < 3; i++) begin
               dr_ff[j][i]   <= dr_in[j][i];
               dq_ff[j][i]   <= dq_in[j][i];
               dneg_ff[j][i] <= dneg_in[j][i];
            end
         end
      end
   end

   assign uout = u_ff;

endmodule

`default_nettype wire

### design/lrae_cordic.sv
`default_nettype none

module lrae_cordic (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [lrae_pkg::CW-1:0]   in_x,
   input  logic signed [lrae_pkg::CW-1:0]   in_y,
   output logic signed [lrae_pkg::CW-1:0]   mag,
   output logic signed [lrae_pkg::AW-1:0]   angle
);
   import lrae_pkg::*;

   logic signed [CW-1:0] x_ff [CORDIC_RUN+1];
   logic signed [CW-1:0] y_ff [CORDIC_RUN+1];
   logic signed [AW-1:0] a_ff [CORDIC_RUN+1];
   logic signed [CW-1:0] x_in [CORDIC_RUN+1];
   logic signed [CW-1:0] y_in [CORDIC_RUN+1];
   logic signed [AW-1:0] a_in [CORDIC_RUN+1];

   always_comb begin
      // fold the left half plane onto the right
      if (in_x[CW-1]) begin
         x_in[0] = -in_x;
         y_in[0] = -in_y;
         a_in[0] = HALF_TURN;
      end else begin
         x_in[0] = in_x;
         y_in[0] = in_y;
         a_in[0] = '0;
      end
      for (int k = 0; k < CORDIC_RUN; k++) begin
         if (!y_ff[k][CW-1]) begin
            x_in[k+1] = x_ff[k] + (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] - (x_ff[k] >>> k);
            a_in[k+1] = a_ff[k] + ATAN_TAB[k];
         end else begin
            x_in[k+1] = x_ff[k] - (y_ff[k] >>> k);
            y_in[k+1] = y_ff[k] + (x_ff[k] >>> k);
            a_in[k+1] = a_ff[k] - ATAN_TAB[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= CORDIC_RUN; k++) begin
            x_ff[k] <= x_in[k];
            y_ff[k] <= y_in[k];
            a_ff[k] <= a_in[k];
         end
      end
   end

   assign mag   = x_ff[CORDIC_RUN];
   assign angle = a_ff[CORDIC_RUN];

endmodule

`default_nettype wire

### design/listener_relative_azimuth_elevation_unit.sv
// Throughput: one transaction per cycle; the whole pipeline holds while a
// response waits on rsp_tready.
// Reset: synchronous, active high; clears the valid bits of every stage.
// The pipeline depth is set by the frame normalization (square root, divide)
// followed by two chained CORDIC vectoring units.
`default_nettype none

module listener_relative_azimuth_elevation_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // source_x, source_y, source_z, listener_x, listener_y, listener_z,
   // forward_x, forward_y, forward_z, upward_x, upward_y, upward_z
   input  logic [lrae_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // azimuth, elevation, distance, zero pad
   output logic [lrae_pkg::RSP_W-1:0]  rsp_tdata
);
   import lrae_pkg::*;

   logic en;
   logic [TOTAL_LAT-1:0] vld_ff;

   comp_type          src_w [3];
   comp_type          lis_w [3];
   logic signed [15:0] fwd_w [3];
   logic signed [15:0] upw_w [3];

   logic signed [32:0] p_ff [3];
   comp_type          f_ff [3];
   comp_type          r_ff [3];
   logic [31:0]       ab_ff [3];
   logic [31:0]       m_ff;
   logic signed [32:0] p2_ff [3];
   logic              deg_ff;
   logic [63:0]       sq_ff [3];
   comp_type          q_ff [3];
   logic [63:0]       rad_ff;
   comp_type          qd_ff [Q_DLY][3];
   logic              gd_ff [G_DLY];
   logic [31:0]       dd_ff [D_DLY];

   logic signed [32:0] ab_w [3];
   logic [31:0]       m_w;
   logic signed [32:0] qh_w [3];
   logic [31:0]       mh_w;
   logic [4:0]        sh_w;
   logic [65:0]       sum_w;
   logic [31:0]       root_w;

   comp_type          at_w [3];
   comp_type          rt_w [3];
   logic signed [63:0] pf_ff [3];
   logic signed [63:0] pr_ff [3];
   logic signed [63:0] pc_ff [6];
   logic signed [CW-1:0] fd_ff;
   logic signed [CW-1:0] rd_ff;
   comp_type          up_ff [3];
   logic signed [63:0] pu_ff [3];
   logic signed [CW-1:0] zd_ff;
   logic signed [CW-1:0] zdd_ff [Z_DLY];

   logic signed [CW-1:0] mag_a;
   logic signed [AW-1:0] ang_a;
   logic signed [AW-1:0] ad_ff [A_DLY];
   logic [51:0]          hp_ff;
   logic signed [CW-1:0] h_w;
   logic signed [CW-1:0] mag_b;
   logic signed [AW-1:0] ang_b;

   logic signed [AXW-1:0] aw_w;
   logic signed [AXW-1:0] at_turn_w;
   logic signed [AXW-1:0] ew_w;
   logic [14:0]           az_w;
   logic [13:0]           el_w;
   logic [60:0]           out_in;
   logic [60:0]           out_ff;

   assign en         = !vld_ff[TOTAL_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[TOTAL_LAT-1];
   assign rsp_tdata  = {3'd0, out_ff};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         src_w[i] = $signed(req_tdata[32*i +: 32]);
         lis_w[i] = $signed(req_tdata[96 + 32*i +: 32]);
         fwd_w[i] = $signed(req_tdata[192 + 16*i +: 16]);
         upw_w[i] = $signed(req_tdata[240 + 16*i +: 16]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_tvalid};
      end
   end

   // relative position, forward, forward x up
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= 33'(src_w[i]) - 33'(lis_w[i]);
            f_ff[i] <= 32'(fwd_w[i]);
         end
         r_ff[0] <= 32'(fwd_w[1] * upw_w[2]) - 32'(fwd_w[2] * upw_w[1]);
         r_ff[1] <= 32'(fwd_w[2] * upw_w[0]) - 32'(fwd_w[0] * upw_w[2]);
         r_ff[2] <= 32'(fwd_w[0] * upw_w[1]) - 32'(fwd_w[1] * upw_w[0]);
      end
   end

   lrae_unit u_unit_at (
      .clock (clock),
      .en    (en),
      .vin   (f_ff),
      .uout  (at_w)
   );

   lrae_unit u_unit_rt (
      .clock (clock),
      .en    (en),
      .vin   (r_ff),
      .uout  (rt_w)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ab_w[i] = p_ff[i][32] ? -p_ff[i] : p_ff[i];
      end
      m_w = ab_w[0][31:0];
      if (ab_w[1][31:0] > m_w) begin
         m_w = ab_w[1][31:0];
      end
      if (ab_w[2][31:0] > m_w) begin
         m_w = ab_w[2][31:0];
      end
      // bring the largest position component into [2^30, 2^31)
      if (m_ff[31]) begin
         for (int i = 0; i < 3; i++) begin
            qh_w[i] = (p2_ff[i] + $signed({32'd0, p2_ff[i][32]})) >>> 1;
         end
         mh_w = m_ff >> 1;
      end else begin
         for (int i = 0; i < 3; i++) begin
            qh_w[i] = p2_ff[i];
         end
         mh_w = m_ff;
      end
      sh_w  = lead_shift(mh_w[30:0]);
      sum_w = 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            ab_ff[i] <= ab_w[i][31:0];
            p2_ff[i] <= p_ff[i];
            sq_ff[i] <= 64'(ab_ff[i]) * 64'(ab_ff[i]);
            q_ff[i]  <= 32'(qh_w[i] <<< sh_w);
         end
         m_ff   <= m_w;
         deg_ff <= (p_ff[0] == '0 && p_ff[1] == '0 && p_ff[2] == '0)
                || (f_ff[0] == '0 && f_ff[1] == '0 && f_ff[2] == '0)
                || (r_ff[0] == '0 && r_ff[1] == '0 && r_ff[2] == '0);
         // saturate: the root of all ones is the largest distance
         rad_ff <= (sum_w[65:64] != 2'd0) ? '1 : sum_w[63:0];
         for (int i = 0; i < 3; i++) begin
            qd_ff[0][i] <= q_ff[i];
            for (int k = 1; k < Q_DLY; k++) begin
               qd_ff[k][i] <= qd_ff[k-1][i];
            end
         end
         gd_ff[0] <= deg_ff;
         for (int k = 1; k < G_DLY; k++) begin
            gd_ff[k] <= gd_ff[k-1];
         end
         dd_ff[0] <= root_w;
         for (int k = 1; k < D_DLY; k++) begin
            dd_ff[k] <= dd_ff[k-1];
         end
      end
   end

   lrae_sqrt u_sqrt_dist (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (root_w)
   );

   // project onto the listener frame
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pf_ff[i] <= 64'(at_w[i] * qd_ff[Q_DLY-3][i]);
            pr_ff[i] <= 64'(rt_w[i] * qd_ff[Q_DLY-3][i]);
         end
         pc_ff[0] <= 64'(rt_w[1] * at_w[2]);
         pc_ff[1] <= 64'(rt_w[2] * at_w[1]);
         pc_ff[2] <= 64'(rt_w[2] * at_w[0]);
         pc_ff[3] <= 64'(rt_w[0] * at_w[2]);
         pc_ff[4] <= 64'(rt_w[0] * at_w[1]);
         pc_ff[5] <= 64'(rt_w[1] * at_w[0]);
         fd_ff <= CW'(trunc_q30(66'(pf_ff[0]) + 66'(pf_ff[1]) + 66'(pf_ff[2])));
         rd_ff <= CW'(trunc_q30(66'(pr_ff[0]) + 66'(pr_ff[1]) + 66'(pr_ff[2])));
         for (int i = 0; i < 3; i++) begin
            up_ff[i] <= 32'(trunc_q30(66'(pc_ff[2*i]) - 66'(pc_ff[2*i+1])));
            pu_ff[i] <= 64'(up_ff[i] * qd_ff[Q_DLY-1][i]);
         end
         zd_ff <= CW'(trunc_q30(66'(pu_ff[0]) + 66'(pu_ff[1]) + 66'(pu_ff[2])));
         zdd_ff[0] <= zd_ff;
         for (int k = 1; k < Z_DLY; k++) begin
            zdd_ff[k] <= zdd_ff[k-1];
         end
         ad_ff[0] <= ang_a;
         for (int k = 1; k < A_DLY; k++) begin
            ad_ff[k] <= ad_ff[k-1];
         end
         hp_ff <= 52'(mag_a[CW-2:0]) * 52'(INV_GAIN);
         out_ff <= out_in;
      end
   end

   lrae_cordic u_cordic_az (
      .clock (clock),
      .en    (en),
      .in_x  (fd_ff),
      .in_y  (rd_ff),
      .mag   (mag_a),
      .angle (ang_a)
   );

   assign h_w = $signed(hp_ff[51:16]);

   lrae_cordic u_cordic_el (
      .clock (clock),
      .en    (en),
      .in_x  (h_w),
      .in_y  (zdd_ff[Z_DLY-1]),
      .mag   (mag_b),
      .angle (ang_b)
   );

   // wrap, round and clamp the angles; zero both when the geometry is degenerate
   always_comb begin
      aw_w = AXW'(ad_ff[A_DLY-1]);
      if (aw_w < 0) begin
         aw_w = aw_w + FULL_TURN;
      end
      if (aw_w >= FULL_TURN) begin
         aw_w = aw_w - FULL_TURN;
      end
      at_turn_w = (aw_w + ROUND_HALF) >>> 10;
      az_w = at_turn_w[14:0];
      if (az_w >= AZ_LIMIT) begin
         az_w = az_w - AZ_LIMIT;
      end
      ew_w = (AXW'(ang_b) + ROUND_HALF) >>> 10;
      if (ew_w > EL_HI) begin
         ew_w = EL_HI;
      end
      if (ew_w < EL_LO) begin
         ew_w = EL_LO;
      end
      el_w = ew_w[13:0];
      if (gd_ff[G_DLY-1]) begin
         az_w = '0;
         el_w = '0;
      end
      out_in = {dd_ff[D_DLY-1], el_w, az_w};
   end

   logic mag_b_unused;
   assign mag_b_unused = ^mag_b;

endmodule

`default_nettype wire

### design/lrae_checker.sv
`default_nettype none

module lrae_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [lrae_pkg::RSP_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response transaction dropped while stalled");

   a_stall_blocks_req: assert property (@(posedge clock)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while the pipeline is stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_az_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:0] < 15'd23040)
      else $error("azimuth out of range");

   a_el_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[28:15]) <= 14'sd5760
                  && $signed(rsp_tdata[28:15]) >= -14'sd5760)
      else $error("elevation out of range");

endmodule

bind listener_relative_azimuth_elevation_unit lrae_checker u_lrae_checker (.*);

`default_nettype wire
